>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge, off in reset
`define ASSERT_IMPL(label, clk_i, rst_n_i, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) \
		else $error("assertion failed");
// condition that must never be seen on a clock edge, off in reset
`define ASSERT_NEVER(label, clk_i, rst_n_i, cond) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(cond)) \
		else $error("assertion failed");
`endif

>>> src/pitt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pitt_pkg
// Shared constants and types for the point-in-tetrahedron test.
// ---------------------------------------------------------------------------
package pitt_pkg;
	localparam int unsigned VertexCountDef = 1024;
	localparam int unsigned CoordWidthDef  = 16;
	localparam int unsigned IdxW           = 10;
	localparam int unsigned InDataW        = 112;
	localparam int unsigned QDepth         = 2;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic [IdxW-1:0] c0;
		logic [IdxW-1:0] c1;
		logic [IdxW-1:0] c2;
		logic [IdxW-1:0] c3;
		logic [IdxW-1:0] pt;
	} query_t;
endpackage

>>> src/pitt_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pitt_front
// Accepts transfers, decodes vertex writes and queues queries.
// ---------------------------------------------------------------------------
module pitt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pitt_pkg::InDataW-1:0] in_data,
	input  logic                         in_user,
	output logic                         wr_en,
	output logic [pitt_pkg::IdxW-1:0]    wr_idx,
	output logic [15:0]                  wr_x,
	output logic [15:0]                  wr_y,
	output logic [15:0]                  wr_z,
	output logic                         q_valid,
	input  logic                         q_ready,
	output pitt_pkg::query_t             q_data
);
	import pitt_pkg::*;

	query_t         fifo_q [QDepth];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	query_t         qin;
	logic           push, pop;

	// writes wait until no query is queued or being evaluated, so that they
	// keep their order with the table reads of earlier queries
	assign in_ready = (in_user == REQ_QUERY) ? (cnt_q != 2'(QDepth)) :
		(cnt_q == 2'd0 && q_ready);
	assign push     = in_valid && in_ready && in_user == REQ_QUERY;
	assign pop      = q_valid && q_ready;
	assign wr_en    = in_valid && in_ready && in_user == REQ_WRITE;
	assign wr_idx   = in_data[9:0];
	assign wr_x     = in_data[25:10];
	assign wr_y     = in_data[41:26];
	assign wr_z     = in_data[57:42];
	assign qin.c0   = in_data[67:58];
	assign qin.c1   = in_data[77:68];
	assign qin.c2   = in_data[87:78];
	assign qin.c3   = in_data[97:88];
	assign qin.pt   = in_data[107:98];
	assign q_valid  = cnt_q != 2'd0;
	assign q_data   = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= qin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> src/pitt_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pitt_back
// Vertex table and sequential same-side evaluation of four faces.
// ---------------------------------------------------------------------------
module pitt_back #(
	parameter int unsigned VERTEX_COUNT = pitt_pkg::VertexCountDef,
	parameter int unsigned COORD_WIDTH  = pitt_pkg::CoordWidthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [pitt_pkg::IdxW-1:0] wr_idx,
	input  logic [15:0]               wr_x,
	input  logic [15:0]               wr_y,
	input  logic [15:0]               wr_z,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  pitt_pkg::query_t          q_data,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic                      res_data
);
	import pitt_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int EW  = CW + 1;
	localparam int NW  = 2 * EW + 1;
	localparam int PW  = NW + EW;
	localparam int SW  = PW + 2;
	localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_CR   = 3'd2;
	localparam logic [2:0] ST_DT   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [3*CW-1:0] mem [VERTEX_COUNT];
	logic [3*CW-1:0] rd_q;
	logic            rd_ok_q;

	logic [2:0]      st_q;
	logic [2:0]      cnt_q;
	logic [1:0]      face_q;
	query_t          qry_q;
	logic signed [CW-1:0] v_q [5][3];
	logic signed [NW-1:0] n_q [3];
	logic signed [SW-1:0] acc1_q, acc2_q;
	logic            ok_q;

	logic [IdxW-1:0] ridx;
	logic [2:0]      ia, ib, ic, io;
	logic signed [EW-1:0] e1 [3], e2 [3], dq [3], dp [3];
	logic signed [NW-1:0] crs [3];
	logic signed [PW-1:0] pq, pp;
	logic [1:0]      k;

	always_comb begin
		unique case (cnt_q)
			3'd0:    ridx = qry_q.c0;
			3'd1:    ridx = qry_q.c1;
			3'd2:    ridx = qry_q.c2;
			3'd3:    ridx = qry_q.c3;
			default: ridx = qry_q.pt;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && 32'(wr_idx) < VERTEX_COUNT)
			mem[AW'(wr_idx)] <= {CW'(wr_z), CW'(wr_y), CW'(wr_x)};
		rd_q    <= mem[AW'(ridx)];
		rd_ok_q <= 32'(ridx) < VERTEX_COUNT;
	end

	always_comb begin
		ia = {1'b0, face_q};
		ib = {1'b0, face_q + 2'd1};
		ic = {1'b0, face_q + 2'd2};
		io = {1'b0, face_q + 2'd3};
		k  = cnt_q[1:0];
		for (int i = 0; i < 3; i++) begin
			e1[i] = EW'(v_q[ib][i]) - EW'(v_q[ia][i]);
			e2[i] = EW'(v_q[ic][i]) - EW'(v_q[ia][i]);
			dq[i] = EW'(v_q[io][i]) - EW'(v_q[ia][i]);
			dp[i] = EW'(v_q[4][i])  - EW'(v_q[ia][i]);
		end
		crs[0] = NW'(e1[1] * e2[2]) - NW'(e1[2] * e2[1]);
		crs[1] = NW'(e1[2] * e2[0]) - NW'(e1[0] * e2[2]);
		crs[2] = NW'(e1[0] * e2[1]) - NW'(e1[1] * e2[0]);
		pq = PW'(n_q[k]) * PW'(dq[k]);
		pp = PW'(n_q[k]) * PW'(dp[k]);
	end

	assign q_ready   = st_q == ST_IDLE;
	assign res_valid = st_q == ST_OUT;
	assign res_data  = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= 3'd0;
			face_q <= 2'd0;
			ok_q   <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q  <= ST_RD;
						cnt_q <= 3'd0;
					end
				end
				ST_RD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						st_q   <= ST_CR;
						face_q <= 2'd0;
						ok_q   <= 1'b1;
					end
				end
				ST_CR: begin
					st_q  <= ST_DT;
					cnt_q <= 3'd0;
				end
				ST_DT: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						if ((acc1_q > 0 && acc2_q < 0) || (acc1_q < 0 && acc2_q > 0))
							ok_q <= 1'b0;
						face_q <= face_q + 2'd1;
						st_q   <= (face_q == 2'd3) ? ST_OUT : ST_CR;
					end
				end
				ST_OUT: if (res_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) qry_q <= q_data;
		if (st_q == ST_RD && cnt_q != 3'd0) begin
			for (int i = 0; i < 3; i++)
				v_q[cnt_q - 3'd1][i] <= rd_ok_q ? rd_q[i*CW +: CW] : '0;
		end
		if (st_q == ST_CR) begin
			for (int i = 0; i < 3; i++) n_q[i] <= crs[i];
			acc1_q <= '0;
			acc2_q <= '0;
		end
		if (st_q == ST_DT && cnt_q != 3'd3) begin
			acc1_q <= acc1_q + SW'(pq);
			acc2_q <= acc2_q + SW'(pp);
		end
	end
endmodule

>>> src/point_in_tetrahedron_test_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_tetrahedron_test_core
// Vertex table with same-side point-in-tetrahedron queries.
// ---------------------------------------------------------------------------
// A write transfer (tuser 0) is taken once no query is queued or under
// evaluation and stores its vertex in the table. A query (tuser 1) passes
// through a queue into the evaluator, which reads its five vertices in turn
// from the one read port of the vertex table, then per face computes the
// cross product and accumulates the dot products on one shared multiplier
// pair. The evaluator takes a new query only once the result of the last
// is taken, so a stalling sink holds it. Up to two queries queue ahead of
// the evaluator. Unwritten slots read as undefined.
`include "assert_macros.svh"
module point_in_tetrahedron_test_core #(
	parameter int unsigned VERTEX_COUNT = pitt_pkg::VertexCountDef,
	parameter int unsigned COORD_WIDTH  = pitt_pkg::CoordWidthDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// vertex_index, coord_x, coord_y, coord_z, corner0..3, point_index, zero pad
	input  logic [pitt_pkg::InDataW-1:0] s_axis_tdata,
	// req_type
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// inside_res, zero pad
	output logic [7:0]                   m_axis_tdata
);
	import pitt_pkg::*;

	logic            wr_en, q_valid, q_ready, res;
	logic [IdxW-1:0] wr_idx;
	logic [15:0]     wr_x, wr_y, wr_z;
	query_t          q_data;

	pitt_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_user(s_axis_tuser),
		.wr_en, .wr_idx, .wr_x, .wr_y, .wr_z,
		.q_valid, .q_ready, .q_data
	);

	pitt_back #(.VERTEX_COUNT(VERTEX_COUNT), .COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk, .arst_n,
		.wr_en, .wr_idx, .wr_x, .wr_y, .wr_z,
		.q_valid, .q_ready, .q_data,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
	);

	assign m_axis_tdata = {7'd0, res};

	`ASSERT_IMPL(a_wr_no_query, clk, arst_n, wr_en |-> !q_valid)
	`ASSERT_IMPL(a_wr_back_idle, clk, arst_n, wr_en |-> q_ready)
	`ASSERT_IMPL(a_res_holds, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
	`ASSERT_NEVER(a_pad_zero, clk, arst_n, m_axis_tdata[7:1] != 7'd0)
endmodule
